// File: hdl/ihx_pkg.sv
// Shared types, constants and helpers for the Intel HEX record parser.
// No dependencies; compiled first.
package ihx_pkg;

    localparam int CHAR_W = 8;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int KIND_W = 3;
    localparam int BUF_W  = 17;

    localparam logic [BUF_W-1:0] BUF_SIZE_RESET = 17'h10000;

    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF_HEX = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;

    localparam logic [7:0] REC_TYPE_DATA = 8'h00;
    localparam logic [7:0] REC_TYPE_EOF  = 8'h01;

    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_SKIP_LINE  = 3'd1,
        PH_LEN        = 3'd2,
        PH_ADDR       = 3'd3,
        PH_TYPE       = 3'd4,
        PH_DATA       = 3'd5,
        PH_CSUM       = 3'd6
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        K_WRITE     = 3'd0,
        K_DATA_OK   = 3'd1,
        K_EOF_OK    = 3'd2,
        K_SKIPPED   = 3'd3,
        K_CSUM_ERR  = 3'd4,
        K_OVERFLOW  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
    } t_result;

    function automatic logic [3:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = '0;
            if (c >= CH_0 && c <= CH_9) begin
                d = c - CH_0;
            end else if (c >= CH_LA && c <= CH_LF_HEX) begin
                d = c - CH_LA + 8'd10;
            end else if (c >= CH_UA && c <= CH_UF) begin
                d = c - CH_UA + 8'd10;
            end
            return d[3:0];
        end
    endfunction

endpackage

// File: hdl/ihx_ifs.sv
// Valid/ready channel interfaces: character input, result output, config write.
// Depends on ihx_pkg.
interface ihx_char_if;
    logic                        valid;
    logic                        ready;
    logic [ihx_pkg::CHAR_W-1:0]  char_in;
    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface ihx_rec_if;
    logic                        valid;
    logic                        ready;
    logic [ihx_pkg::KIND_W-1:0]  kind;
    logic [ihx_pkg::ADDR_W-1:0]  write_address;
    logic [ihx_pkg::DATA_W-1:0]  write_data;
    modport source (output valid, output kind, output write_address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input write_address, input write_data,
                    output ready);
endinterface

interface ihx_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ihx_pkg::BUF_W-1:0]   buffer_size;
    modport source (output valid, output buffer_size, input ready);
    modport sink   (input valid, input buffer_size, output ready);
endinterface

// File: hdl/ihx_parse_core.sv
// Record parser state and next-state logic; one character per step.
// Depends on ihx_pkg.
module ihx_parse_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [ihx_pkg::CHAR_W-1:0] i_char,
    input  logic [ihx_pkg::BUF_W-1:0]  i_buffer_size,
    output logic                       o_res_vld,
    output ihx_pkg::t_result           o_res,
    output logic                       o_halted
);
    import ihx_pkg::*;

    t_phase             r_phase, n_phase;
    logic [3:0]         r_high, n_high;
    logic               r_pend, n_pend;
    logic               r_idx, n_idx;
    logic [7:0]         r_left, n_left;
    logic [ADDR_W-1:0]  r_rec_addr, n_rec_addr;
    logic [ADDR_W-1:0]  r_next_addr, n_next_addr;
    logic [7:0]         r_type, n_type;
    logic [7:0]         r_sum, n_sum;
    logic               r_halted, n_halted;

    logic [3:0]         nib;
    logic [7:0]         byte_val;
    logic [7:0]         sum_b;
    logic [BUF_W-1:0]   rec_end;

    assign nib      = digit_value(i_char);
    assign byte_val = {r_high, nib};
    assign sum_b    = r_sum + byte_val;
    assign rec_end  = {1'b0, r_rec_addr} + {{(BUF_W-8){1'b0}}, r_left};

    always_comb begin
        n_phase     = r_phase;
        n_high      = r_high;
        n_pend      = r_pend;
        n_idx       = r_idx;
        n_left      = r_left;
        n_rec_addr  = r_rec_addr;
        n_next_addr = r_next_addr;
        n_type      = r_type;
        n_sum       = r_sum;
        n_halted    = r_halted;
        o_res_vld   = 1'b0;
        o_res.kind  = K_WRITE;
        o_res.addr  = r_rec_addr;
        o_res.data  = '0;

        if (i_step && !r_halted) begin
            if (i_char == CH_LF) begin
                n_phase = PH_LINE_START;
                n_pend  = 1'b0;
            end else if (r_phase == PH_LINE_START) begin
                if (i_char == CH_COLON) begin
                    n_sum   = '0;
                    n_pend  = 1'b0;
                    n_idx   = 1'b0;
                    n_phase = PH_LEN;
                end else if (i_char != CH_SPACE) begin
                    n_phase = PH_SKIP_LINE;
                end
            end else if (r_phase == PH_SKIP_LINE) begin
                n_phase = PH_SKIP_LINE;
            end else if (!r_pend) begin
                n_high = nib;
                n_pend = 1'b1;
            end else begin
                n_pend = 1'b0;
                n_sum  = sum_b;
                unique case (r_phase)
                    PH_LEN: begin
                        n_left  = byte_val;
                        n_idx   = 1'b0;
                        n_phase = PH_ADDR;
                    end
                    PH_ADDR: begin
                        if (!r_idx) begin
                            n_rec_addr = {byte_val, 8'h00};
                            n_idx      = 1'b1;
                        end else begin
                            n_rec_addr = {r_rec_addr[ADDR_W-1:8], byte_val};
                            n_idx      = 1'b0;
                            n_phase    = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        n_type      = byte_val;
                        n_next_addr = r_rec_addr;
                        if (byte_val == REC_TYPE_DATA && rec_end > i_buffer_size) begin
                            n_halted   = 1'b1;
                            o_res_vld  = 1'b1;
                            o_res.kind = K_OVERFLOW;
                        end else begin
                            n_phase = (r_left != 8'd0) ? PH_DATA : PH_CSUM;
                        end
                    end
                    PH_DATA: begin
                        if (r_type == REC_TYPE_DATA) begin
                            o_res_vld  = 1'b1;
                            o_res.kind = K_WRITE;
                            o_res.addr = r_next_addr;
                            o_res.data = byte_val;
                        end
                        n_next_addr = r_next_addr + 16'd1;
                        n_left      = r_left - 8'd1;
                        if (r_left == 8'd1) begin
                            n_phase = PH_CSUM;
                        end
                    end
                    PH_CSUM: begin
                        n_phase   = PH_SKIP_LINE;
                        o_res_vld = 1'b1;
                        if (sum_b != 8'd0) begin
                            n_halted   = 1'b1;
                            o_res.kind = K_CSUM_ERR;
                        end else if (r_type == REC_TYPE_DATA) begin
                            o_res.kind = K_DATA_OK;
                        end else if (r_type == REC_TYPE_EOF) begin
                            n_halted   = 1'b1;
                            o_res.kind = K_EOF_OK;
                        end else begin
                            o_res.kind = K_SKIPPED;
                        end
                    end
                    default: begin
                        n_phase = PH_SKIP_LINE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE_START;
            r_high      <= '0;
            r_pend      <= 1'b0;
            r_idx       <= 1'b0;
            r_left      <= '0;
            r_rec_addr  <= '0;
            r_next_addr <= '0;
            r_type      <= '0;
            r_sum       <= '0;
            r_halted    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_high      <= n_high;
            r_pend      <= n_pend;
            r_idx       <= n_idx;
            r_left      <= n_left;
            r_rec_addr  <= n_rec_addr;
            r_next_addr <= n_next_addr;
            r_type      <= n_type;
            r_sum       <= n_sum;
            r_halted    <= n_halted;
        end
    end

    assign o_halted = r_halted;

endmodule

// File: hdl/ihx_out_reg.sv
// Result register driving the output channel; holds a result until transferred.
// Depends on ihx_pkg and ihx_rec_if.
module ihx_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ihx_pkg::t_result i_res,
    output logic             o_busy,
    ihx_rec_if.source        o_rec
);
    import ihx_pkg::*;

    logic    r_vld;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_rec.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_busy              = r_vld && !o_rec.ready;
    assign o_rec.valid         = r_vld;
    assign o_rec.kind          = r_res.kind;
    assign o_rec.write_address = r_res.addr;
    assign o_rec.write_data    = r_res.data;

endmodule

// File: hdl/intel_hex_record_parser.sv
// Intel HEX record parser top level: input register, parser core, result register.
// Depends on ihx_pkg, ihx_ifs, ihx_parse_core, ihx_out_reg.
//
// Takes one character per clock cycle and sustains that rate indefinitely while
// results are taken. A character lands in the input register, is parsed by the
// core once the result register is not holding back an untaken result, and any
// result it causes is loaded into the result register at the end of the parse cycle.
// The input is stalled only while the input register is full and the result
// register holds a result that has not been transferred. buffer_size is written
// through the configuration channel, which is always ready, and must only be
// written while the parser is idle. After an end-of-file record, a checksum
// error or an overflow error, all input is consumed and ignored until reset.
module intel_hex_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ihx_char_if.sink    i_char,
    ihx_cfg_if.sink     i_cfg,
    ihx_rec_if.source   o_rec
);
    import ihx_pkg::*;

    logic               r_in_vld;
    logic [CHAR_W-1:0]  r_char;
    logic [BUF_W-1:0]   r_buffer_size;
    logic               out_busy;
    logic               advance;
    logic               res_vld;
    t_result            res;
    logic               halted;

    assign advance      = r_in_vld && !out_busy;
    assign i_char.ready = !r_in_vld || advance;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_char.ready) begin
            r_in_vld <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_char <= i_char.char_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUF_SIZE_RESET;
        end else if (i_cfg.valid) begin
            r_buffer_size <= i_cfg.buffer_size;
        end
    end

    ihx_parse_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_char        (r_char),
        .i_buffer_size (r_buffer_size),
        .o_res_vld     (res_vld),
        .o_res         (res),
        .o_halted      (halted)
    );

    ihx_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_vld),
        .i_res   (res),
        .o_busy  (out_busy),
        .o_rec   (o_rec)
    );

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        halted |-> !res_vld)
        else $error("result produced while halted");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> (r_in_vld && $stable(r_char)))
        else $error("stalled character lost or changed");

    a_status_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_vld && res.kind != K_WRITE) |-> (res.data == '0))
        else $error("status result carries nonzero data");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |-> !out_busy)
        else $error("result register overwritten");

endmodule

// File: tb/ihx_record_checker.sv
`timescale 1ns / 1ps
// Result checker for the Intel HEX record parser: follows character and config
// transfers, predicts the result records, and compares every result transfer.
// Depends on ihx_pkg and ihx_ifs.
module ihx_record_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ihx_char_if  i_char,
    ihx_cfg_if   i_cfg,
    ihx_rec_if   i_rec,
    output int   o_fail_count,
    output int   o_pending_count
);
    import ihx_pkg::*;

    t_result          expected_records[$];
    int               mismatches = 0;

    logic [BUF_W-1:0] buf_size;
    t_phase           field_phase;
    logic [3:0]       hi_nib;
    logic             nib_pend;
    logic             byte_idx;
    logic [7:0]       remaining;
    logic [15:0]      rec_addr;
    logic [15:0]      next_addr;
    logic [7:0]       rec_type;
    logic [7:0]       sum;
    logic             halted;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return c[3:0];
        if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF_HEX)) return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    function automatic void queue_result(input t_kind k, input logic [15:0] a,
                                         input logic [7:0] d);
        expected_records.push_back(t_result'{k, a, d});
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic [7:0] b;
        if (halted) return;
        if (c == CH_LF) begin
            field_phase = PH_LINE_START;
            nib_pend = 1'b0;
            return;
        end
        if (field_phase == PH_LINE_START) begin
            if (c == CH_SPACE) return;
            if (c == CH_COLON) begin
                sum = 8'h00;
                nib_pend = 1'b0;
                byte_idx = 1'b0;
                field_phase = PH_LEN;
            end else begin
                field_phase = PH_SKIP_LINE;
            end
            return;
        end
        if (field_phase == PH_SKIP_LINE) return;
        if (!nib_pend) begin
            hi_nib = hex_nibble(c);
            nib_pend = 1'b1;
            return;
        end
        nib_pend = 1'b0;
        b = {hi_nib, hex_nibble(c)};
        sum = sum + b;
        case (field_phase)
            PH_LEN: begin
                remaining = b;
                byte_idx = 1'b0;
                field_phase = PH_ADDR;
            end
            PH_ADDR: begin
                if (!byte_idx) begin
                    rec_addr = {b, 8'h00};
                    byte_idx = 1'b1;
                end else begin
                    rec_addr[7:0] = b;
                    byte_idx = 1'b0;
                    field_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                rec_type = b;
                next_addr = rec_addr;
                if (rec_type == REC_TYPE_DATA &&
                    ({1'b0, rec_addr} + {9'h000, remaining}) > buf_size) begin
                    halted = 1'b1;
                    queue_result(K_OVERFLOW, rec_addr, 8'h00);
                end else begin
                    field_phase = (remaining != 8'h00) ? PH_DATA : PH_CSUM;
                end
            end
            PH_DATA: begin
                if (rec_type == REC_TYPE_DATA) queue_result(K_WRITE, next_addr, b);
                next_addr = next_addr + 16'd1;
                remaining = remaining - 8'd1;
                if (remaining == 8'h00) field_phase = PH_CSUM;
            end
            PH_CSUM: begin
                field_phase = PH_SKIP_LINE;
                if (sum != 8'h00) begin
                    halted = 1'b1;
                    queue_result(K_CSUM_ERR, rec_addr, 8'h00);
                end else if (rec_type == REC_TYPE_DATA) begin
                    queue_result(K_DATA_OK, rec_addr, 8'h00);
                end else if (rec_type == REC_TYPE_EOF) begin
                    halted = 1'b1;
                    queue_result(K_EOF_OK, rec_addr, 8'h00);
                end else begin
                    queue_result(K_SKIPPED, rec_addr, 8'h00);
                end
            end
            default: begin
                field_phase = PH_SKIP_LINE;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            buf_size = BUF_SIZE_RESET;
            field_phase = PH_LINE_START;
            hi_nib = 4'h0;
            nib_pend = 1'b0;
            byte_idx = 1'b0;
            remaining = 8'h00;
            rec_addr = 16'h0000;
            next_addr = 16'h0000;
            rec_type = 8'h00;
            sum = 8'h00;
            halted = 1'b0;
            expected_records.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) buf_size = i_cfg.buffer_size;
            if (i_char.valid && i_char.ready) parse_char(i_char.char_in);
            if (i_rec.valid && i_rec.ready) begin
                if (expected_records.size() == 0) begin
                    $error("unexpected result: kind %0d, address %h, data %h",
                           i_rec.kind, i_rec.write_address, i_rec.write_data);
                    mismatches++;
                end else begin
                    want = expected_records.pop_front();
                    if (i_rec.kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, i_rec.kind);
                        mismatches++;
                    end
                    if (i_rec.write_address !== want.addr) begin
                        $error("write_address: expected %h, actual %h",
                               want.addr, i_rec.write_address);
                        mismatches++;
                    end
                    if (i_rec.write_data !== want.data) begin
                        $error("write_data: expected %h, actual %h",
                               want.data, i_rec.write_data);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending_count <= expected_records.size();
    end

endmodule

// File: tb/intel_hex_record_parser_tb.sv
`timescale 1ns / 1ps
// Top of the Intel HEX record parser testbench: clock, reset, hex text and
// buffer size stimulus, result back-pressure, watchdog and verdict.
// Depends on ihx_pkg, ihx_ifs, intel_hex_record_parser and ihx_record_checker.
module intel_hex_record_parser_tb;
    import ihx_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int LONG_HOLD  = 120;
    localparam int HOLD_AFTER = 150;
    localparam int SIZE_STEPS = 6;

    typedef enum int {
        END_EOF,
        END_EOF_BAD_SUM,
        END_DATA_BAD_SUM,
        END_OVERFLOW
    } t_ending;

    logic    clk = 1'b0;
    logic    rst_n;
    int      cur_size;
    int      chars_sent = 0;
    int      accepted_chars = 0;
    int      results_seen = 0;
    int      idle_cycles = 0;
    int      fail_count;
    int      pending;
    bit      calm = 1'b0;
    t_ending ending;
    int      size_plan [SIZE_STEPS] = '{65536, 0, 1, 0, 131071, 65536};
    int      char_budget [SIZE_STEPS] = '{280, 40, 40, 70, 110, 40};

    ihx_char_if char_if ();
    ihx_cfg_if  cfg_if ();
    ihx_rec_if  rec_if ();

    intel_hex_record_parser DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_char  (char_if),
        .i_cfg   (cfg_if),
        .o_rec   (rec_if)
    );

    ihx_record_checker record_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_char          (char_if),
        .i_cfg           (cfg_if),
        .i_rec           (rec_if),
        .o_fail_count    (fail_count),
        .o_pending_count (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && char_if.valid && char_if.ready) accepted_chars <= accepted_chars + 1;
        if (rst_n && rec_if.valid && rec_if.ready) results_seen <= results_seen + 1;
    end

    // watchdog: cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (char_if.valid && char_if.ready) || (rec_if.valid && rec_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bit held_long;
        held_long = 1'b0;
        rec_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (!held_long && accepted_chars >= HOLD_AFTER) begin
                rec_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                held_long = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                rec_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                rec_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do c = text_char(); while ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
                                   (c >= CH_LA && c <= CH_LF_HEX));
        return c;
    endfunction

    // zero nibbles sometimes go out as arbitrary non-hex characters
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v == 4'd0 && $urandom_range(0, 5) == 0) return non_hex_char();
        if (v < 4'd10) return CH_0 + {4'h0, v};
        return (($urandom_range(0, 1) == 1) ? CH_UA : CH_LA) + {4'h0, v} - 8'd10;
    endfunction

    task automatic send_char(input logic [7:0] c);
        if (!calm && $urandom_range(0, 7) == 0) begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        char_if.valid   <= 1'b1;
        char_if.char_in <= c;
        @(posedge clk);
        while (!char_if.ready) @(posedge clk);
        chars_sent++;
    endtask

    // cut >= 0: newline after that many hex digits; tail: junk after the checksum
    task automatic send_record(input int spaces, input int len, input logic [15:0] addr,
                               input logic [7:0] rtype, input bit good_sum,
                               input int cut, input int tail);
        logic [7:0] rec_bytes[$];
        logic [7:0] text[$];
        logic [7:0] total;
        int         digits;
        total = 8'h00;
        digits = 0;
        rec_bytes = {len[7:0], addr[15:8], addr[7:0], rtype};
        repeat (len) rec_bytes.push_back(8'($urandom_range(0, 255)));
        foreach (rec_bytes[k]) total = total + rec_bytes[k];
        total = 8'h00 - total;
        if (!good_sum) total = total + 8'($urandom_range(1, 255));
        rec_bytes.push_back(total);
        repeat (spaces) text.push_back(CH_SPACE);
        text.push_back(CH_COLON);
        foreach (rec_bytes[k]) begin
            for (int h = 1; h >= 0; h--) begin
                if (cut < 0 || digits < cut) begin
                    text.push_back(hex_char(rec_bytes[k][4*h +: 4]));
                    digits++;
                end
            end
        end
        if (cut < 0) repeat (tail) text.push_back(text_char());
        text.push_back(CH_LF);
        foreach (text[k]) send_char(text[k]);
    endtask

    task automatic send_noise_line(input bit blank);
        logic [7:0] text[$];
        logic [7:0] c;
        repeat ($urandom_range(0, 3)) text.push_back(CH_SPACE);
        if (!blank) begin
            do c = text_char(); while (c == CH_SPACE || c == CH_COLON);
            text.push_back(c);
            repeat ($urandom_range(0, 10)) text.push_back(text_char());
        end
        text.push_back(CH_LF);
        foreach (text[k]) send_char(text[k]);
    endtask

    // never halts: data records stay inside the buffer, checksums are good,
    // end-of-file records only appear cut short
    task automatic send_random_line();
        int          pick;
        int          len;
        int          lim;
        int          cut;
        bit          is_data;
        logic [15:0] addr;
        logic [7:0]  rtype;
        pick = $urandom_range(0, 99);
        if (pick >= 85) begin
            send_noise_line(pick >= 95);
            return;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        is_data = (pick < 60) || (pick >= 75 && $urandom_range(0, 1) == 1);
        cut = (pick >= 75) ? $urandom_range(0, 2 * len + 9) : -1;
        if (is_data) begin
            rtype = REC_TYPE_DATA;
            if (len > cur_size) len = cur_size;
            lim = cur_size - len;
            if (lim > 65535) lim = 65535;
            addr = 16'($urandom_range(0, lim));
        end else begin
            rtype = 8'($urandom_range((cut >= 0) ? 1 : 2, 255));
            addr = 16'($urandom);
        end
        send_record($urandom_range(0, 2), len, addr, rtype, 1'b1, cut,
                    ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0);
    endtask

    task automatic settle();
        char_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_buffer_size(input logic [BUF_W-1:0] value);
        cfg_if.valid       <= 1'b1;
        cfg_if.buffer_size <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int start;
        int len;
        char_if.valid      <= 1'b0;
        char_if.char_in    <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.buffer_size <= '0;
        rst_n              <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < SIZE_STEPS; p++) begin
            settle();
            cur_size = (p == 3) ? $urandom_range(2, 65535) : size_plan[p];
            write_buffer_size(cur_size[BUF_W-1:0]);
            start = chars_sent;
            if (p == 0) begin
                send_record(1, 1, 16'hFFFF, REC_TYPE_DATA, 1'b1, -1, 1);
                send_record(0, 0, 16'h0000, REC_TYPE_DATA, 1'b1, 1, 0);
                send_noise_line(1'b0);
                send_record(0, 100, 16'($urandom_range(0, 65536 - 100)), REC_TYPE_DATA,
                            1'b1, -1, 0);
            end
            if (p == 4) send_record(0, 32, 16'hFFF0, REC_TYPE_DATA, 1'b1, -1, 0);
            while (chars_sent - start < char_budget[p]) send_random_line();
        end

        // last part: no idling, two random lines, one terminating record, then ignored input
        calm = 1'b1;
        repeat (2) send_random_line();
        ending = t_ending'($urandom_range(0, 3));
        case (ending)
            END_EOF: begin
                send_record(0, 0, 16'($urandom), REC_TYPE_EOF, 1'b1, -1, 2);
            end
            END_EOF_BAD_SUM: begin
                send_record(0, $urandom_range(0, 4), 16'($urandom), REC_TYPE_EOF, 1'b0, -1, 0);
            end
            END_DATA_BAD_SUM: begin
                len = $urandom_range(1, 8);
                send_record(0, len, 16'($urandom_range(0, 65536 - len)), REC_TYPE_DATA,
                            1'b0, -1, 0);
            end
            default: begin
                len = $urandom_range(2, 16);
                send_record(0, len, 16'($urandom_range(65537 - len, 65535)), REC_TYPE_DATA,
                            1'b1, -1, 0);
            end
        endcase
        repeat (2) send_random_line();
        settle();
        repeat (6) @(posedge clk);

        $display("Run summary: %0d characters in, %0d results out, buffer sizes 0 to 131071",
                 accepted_chars, results_seen);
        $display("with address wrap, long output stall, terminated by %s.", ending.name());
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/ihx_pkg.sv
hdl/ihx_ifs.sv
hdl/ihx_parse_core.sv
hdl/ihx_out_reg.sv
hdl/intel_hex_record_parser.sv
tb/ihx_record_checker.sv
tb/intel_hex_record_parser_tb.sv
